// ===== src/cdm_pkg.sv =====
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared codes and types for the constant divider: divide modes, register
// indexes and the final correction applied after the shift stage.
// ----------------------------------------------------------------------------
package cdm_pkg;

  // width of the numerator, result and configuration data fields
  localparam int FIELD_W = 32;
  // signed operand width of the multipliers
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_UNSIGNED  = 3'd0;
  localparam mode_t MODE_SIGNED    = 3'd1;
  localparam mode_t MODE_BY_ONE    = 3'd2;
  localparam mode_t MODE_BY_NEG1   = 3'd3;
  localparam mode_t MODE_POW2      = 3'd4;
  localparam mode_t MODE_NEG_POW2  = 3'd5;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_DIVISOR   = 3'd0;
  localparam cfg_index_t REG_MAGIC     = 3'd1;
  localparam cfg_index_t REG_PRE_SHIFT = 3'd2;
  localparam cfg_index_t REG_POST      = 3'd3;
  localparam cfg_index_t REG_ADD_FIXUP = 3'd4;
  localparam cfg_index_t REG_MODE      = 3'd5;

  typedef enum logic [1:0] {
    FIN_PASS,
    FIN_ROUND,
    FIN_NEGATE
  } fin_t;

endpackage

// ===== src/constant_divider_magic_multiply_top.sv =====
// ----------------------------------------------------------------------------
// constant_divider_magic_multiply_top
// Division by a configured constant through a magic-number multiply, with
// quotient or remainder select per transaction.
// Six register stages, stage one to stage six, the last one holding the result.
// Throughput: one transaction per cycle; the stages stall together only where
// a full stage meets a stalled successor, so bubbles are squeezed out.
// The stage-one and stage-four multipliers (33 x 33 signed) set the stage depth.
// Reset clears the stage valid bits and loads the registers with divisor 1,
// magic 0, shifts 0, no fixup and divide-by-one mode.
// ----------------------------------------------------------------------------
module constant_divider_magic_multiply_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cdm_pkg::FIELD_W-1:0] numerator,
  input  logic                        op,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cdm_pkg::FIELD_W-1:0] result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  cdm_pkg::cfg_index_t         cfg_index,
  input  logic [cdm_pkg::FIELD_W-1:0] cfg_data
);
  import cdm_pkg::*;

  localparam int XW   = 2 * DATA_WIDTH + 68;  // scratch width for extensions
  localparam int NSTG = 6;

  // configuration registers
  logic [FIELD_W-1:0] divisor;
  logic [FIELD_W-1:0] magic;
  logic [4:0]         pre_shift;
  logic [5:0]         post_shift;
  logic               add_fixup;
  mode_t              divide_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor     <= FIELD_W'(1);
      magic       <= '0;
      pre_shift   <= '0;
      post_shift  <= '0;
      add_fixup   <= 1'b0;
      divide_mode <= MODE_BY_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIVISOR:   divisor     <= cfg_data;
        REG_MAGIC:     magic       <= cfg_data;
        REG_PRE_SHIFT: pre_shift   <= cfg_data[4:0];
        REG_POST:      post_shift  <= cfg_data[5:0];
        REG_ADD_FIXUP: add_fixup   <= cfg_data[0];
        REG_MODE:      divide_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // derived operands; the user must keep them static while transactions are in flight (not enforced here)
  logic                   div_sx;
  logic                   mode_sgn;
  logic [XW-1:0]          div_x;
  logic [DATA_WIDTH-1:0]  div_w;
  logic [XW-1:0]          mag_x;
  logic [DATA_WIDTH-1:0]  mag_w;
  logic [XW-1:0]          mag_sx;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [MUL_W-1:0] div_m;

  always_comb begin
    mode_sgn = (divide_mode == MODE_SIGNED);
    div_sx   = mode_sgn || (divide_mode == MODE_BY_NEG1) || (divide_mode == MODE_NEG_POW2);
    div_x    = {{(XW-FIELD_W){div_sx & divisor[FIELD_W-1]}}, divisor};
    div_w    = div_x[DATA_WIDTH-1:0];
    mag_x    = {{(XW-FIELD_W){mode_sgn & magic[FIELD_W-1]}}, magic};
    mag_w    = mag_x[DATA_WIDTH-1:0];
    mag_sx   = {{(XW-DATA_WIDTH){mode_sgn & mag_w[DATA_WIDTH-1]}}, mag_w};
    mul_b    = mag_sx[MUL_W-1:0];
    div_m    = div_x[MUL_W-1:0];
  end

  // pipeline control: a stage loads when its predecessor is valid and it is empty or its successor moves
  logic [NSTG:1] vld;
  logic [NSTG:1] rdy;
  logic [NSTG:1] vprev;
  logic [NSTG:1] ld;

  always_comb begin
    rdy[NSTG] = !vld[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vprev = {vld[NSTG-1:1], in_valid};
    ld    = rdy & vprev;
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) vld[k] <= vprev[k];
      end
    end
  end

  // stage registers
  logic signed [MUL_W-1:0]  s1_a;
  logic signed [MUL_W-1:0]  s1_b;
  logic [DATA_WIDTH-1:0]    s1_n;
  logic                     s1_op;
  logic signed [PROD_W-1:0] s2_prod;
  logic [DATA_WIDTH-1:0]    s2_n;
  logic                     s2_op;
  logic [DATA_WIDTH-1:0]    s3_t;
  logic                     s3_arith;
  logic [5:0]               s3_amt;
  fin_t                     s3_fin;
  logic [DATA_WIDTH-1:0]    s3_n;
  logic                     s3_op;
  logic [DATA_WIDTH-1:0]    s4_q;
  logic [DATA_WIDTH-1:0]    s4_n;
  logic                     s4_op;
  logic signed [PROD_W-1:0] s5_p0;
  logic signed [PROD_W-1:0] s5_p1;
  logic [DATA_WIDTH-1:0]    s5_q;
  logic [DATA_WIDTH-1:0]    s5_n;
  logic                     s5_op;

  // stage 1 input: pre-shift and operand extension
  logic [XW-1:0]           num_x;
  logic [DATA_WIDTH-1:0]   num_w;
  logic [DATA_WIDTH-1:0]   pre_sh;
  logic [XW-1:0]           a_ext;

  always_comb begin
    num_x  = {{(XW-FIELD_W){1'b0}}, numerator};
    num_w  = num_x[DATA_WIDTH-1:0];
    pre_sh = (32'(pre_shift) >= 32'(DATA_WIDTH)) ? '0 : (num_w >> pre_shift);
    if (mode_sgn) a_ext = {{(XW-DATA_WIDTH){num_w[DATA_WIDTH-1]}}, num_w};
    else          a_ext = {{(XW-DATA_WIDTH){1'b0}}, pre_sh};
  end

  // stage 2 input: magic product
  logic signed [PROD_W-1:0] mul_prod;
  assign mul_prod = s1_a * s1_b;

  // stage 3 input: high half, fixup adds, shift setup
  logic [XW-1:0]         prod_x;
  logic [DATA_WIDTH-1:0] hi;
  logic [DATA_WIDTH-1:0] diff;
  logic [DATA_WIDTH-1:0] npq;
  logic [DATA_WIDTH-1:0] one_w;
  logic [DATA_WIDTH-1:0] bias;
  logic [5:0]            post_m1;
  logic [5:0]            k_sat;
  logic [DATA_WIDTH-1:0] t_next;
  logic                  arith_next;
  logic [5:0]            amt_next;
  fin_t                  fin_next;

  always_comb begin
    prod_x  = {{(XW-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
    hi      = prod_x[DATA_WIDTH +: DATA_WIDTH];
    diff    = s2_n - hi;
    npq     = {1'b0, diff[DATA_WIDTH-1:1]} + hi;
    one_w   = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    post_m1 = (post_shift == 6'd0) ? 6'd0 : post_shift - 6'd1;
    k_sat   = (32'(post_shift) > 32'(DATA_WIDTH - 1)) ? 6'(DATA_WIDTH - 1) : post_shift;
    // round toward zero for negative numerators in the power of two modes
    bias    = s2_n[DATA_WIDTH-1] ? ((one_w << k_sat) - one_w) : '0;
    t_next     = s2_n;
    arith_next = 1'b0;
    amt_next   = 6'd0;
    fin_next   = FIN_PASS;
    case (divide_mode)
      MODE_UNSIGNED: begin
        t_next   = add_fixup ? npq : hi;
        amt_next = add_fixup ? post_m1 : post_shift;
      end
      MODE_SIGNED: begin
        t_next = hi;
        if (!div_w[DATA_WIDTH-1] && (div_w != '0) && mag_w[DATA_WIDTH-1]) begin
          t_next = hi + s2_n;
        end else if (div_w[DATA_WIDTH-1] && !mag_w[DATA_WIDTH-1] && (mag_w != '0)) begin
          t_next = hi - s2_n;
        end
        arith_next = 1'b1;
        amt_next   = k_sat;
        fin_next   = FIN_ROUND;
      end
      MODE_BY_NEG1: begin
        t_next = '0 - s2_n;
      end
      MODE_POW2, MODE_NEG_POW2: begin
        t_next     = s2_n + bias;
        arith_next = 1'b1;
        amt_next   = k_sat;
        fin_next   = (divide_mode == MODE_NEG_POW2) ? FIN_NEGATE : FIN_PASS;
      end
      default: begin
        t_next = s2_n;
      end
    endcase
  end

  // stage 4 input: final shift and correction
  logic signed [DATA_WIDTH-1:0] t_s;
  logic [DATA_WIDTH-1:0]        shv;
  logic [DATA_WIDTH-1:0]        q_next;

  always_comb begin
    t_s = s3_t;
    if (s3_arith)                                shv = $unsigned(t_s >>> s3_amt);
    else if (32'(s3_amt) >= 32'(DATA_WIDTH))     shv = '0;
    else                                         shv = s3_t >> s3_amt;
    case (s3_fin)
      FIN_ROUND:  q_next = shv + {{(DATA_WIDTH-1){1'b0}}, shv[DATA_WIDTH-1]};
      FIN_NEGATE: q_next = '0 - shv;
      default:    q_next = shv;
    endcase
  end

  // stage 5 input: quotient times divisor as two partial products
  logic [XW-1:0]            q_x;
  logic signed [MUL_W-1:0]  q_lo;
  logic signed [MUL_W-1:0]  q_hi;
  logic signed [PROD_W-1:0] mul0;
  logic signed [PROD_W-1:0] mul1;

  always_comb begin
    q_x  = {{(XW-DATA_WIDTH){1'b0}}, s4_q};
    q_lo = {1'b0, q_x[31:0]};
    q_hi = {1'b0, q_x[63:32]};
    mul0 = q_lo * div_m;
    mul1 = q_hi * div_m;
  end

  // stage 6 input: remainder and select
  logic [XW-1:0]         p0_x;
  logic [XW-1:0]         p1_x;
  logic [DATA_WIDTH-1:0] mul_lo;
  logic [DATA_WIDTH-1:0] rem;
  logic [XW-1:0]         res_x;

  always_comb begin
    p0_x   = {{(XW-PROD_W){s5_p0[PROD_W-1]}}, s5_p0};
    p1_x   = {{(XW-PROD_W){s5_p1[PROD_W-1]}}, s5_p1} << 32;
    mul_lo = p0_x[DATA_WIDTH-1:0] + p1_x[DATA_WIDTH-1:0];
    rem    = s5_n - mul_lo;
    res_x  = {{(XW-DATA_WIDTH){1'b0}}, (s5_op ? rem : s5_q)};
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_a  <= a_ext[MUL_W-1:0];
      s1_b  <= mul_b;
      s1_n  <= num_w;
      s1_op <= op;
    end
    if (ld[2]) begin
      s2_prod <= mul_prod;
      s2_n    <= s1_n;
      s2_op   <= s1_op;
    end
    if (ld[3]) begin
      s3_t     <= t_next;
      s3_arith <= arith_next;
      s3_amt   <= amt_next;
      s3_fin   <= fin_next;
      s3_n     <= s2_n;
      s3_op    <= s2_op;
    end
    if (ld[4]) begin
      s4_q  <= q_next;
      s4_n  <= s3_n;
      s4_op <= s3_op;
    end
    if (ld[5]) begin
      s5_p0 <= mul0;
      s5_p1 <= mul1;
      s5_q  <= s4_q;
      s5_n  <= s4_n;
      s5_op <= s4_op;
    end
    if (ld[6]) begin
      result <= res_x[FIELD_W-1:0];
    end
  end

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[1])
    else $error("accepted transaction did not reach stage one");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld) && !out_ready)
    else $error("input stalled while the pipeline has room");

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !rdy[3] |=> vld[3] && $stable(s3_t))
    else $error("stalled stage three lost its contents");

  a_reach_out: assert property (@(posedge clk) disable iff (rst)
    vld[5] && rdy[5] |=> out_valid)
    else $error("stage five advance did not produce an output");

endmodule
